FILE: rtl/core/lbr_pkg.sv
// Package for the 2D lattice basis reduction block.
// Holds widths, the controller state type and the command/status structs.
package lbr_pkg;

  localparam int unsigned CompWidth = 16;
  localparam int unsigned OutWidth  = CompWidth + 1;
  localparam int unsigned CandWidth = OutWidth + 1;
  localparam int unsigned SqWidth   = 2 * CandWidth;
  localparam int unsigned SumWidth  = SqWidth + 1;

  typedef logic signed [CompWidth-1:0] comp_t;
  typedef logic signed [OutWidth-1:0]  vec_t;
  typedef logic signed [CandWidth-1:0] cand_t;
  typedef logic [SqWidth-1:0]          sq_t;
  typedef logic [SumWidth-1:0]         sum_t;

  // step[1]: sign of the step (0 = minus, 1 = plus); step[0]: target (0 = a, 1 = b)
  typedef logic [1:0] step_t;

  localparam step_t StepLast = 2'b11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAND,
    ST_SQ,
    ST_SUM,
    ST_CMP,
    ST_OUT
  } lbr_state_e;

  typedef struct packed {
    logic  load;
    logic  cand;
    logic  sq;
    logic  sum;
    logic  cmp;
    logic  store_out;
    step_t step;
  } lbr_cmd_t;

  typedef struct packed {
    logic shorter;
  } lbr_sts_t;

endpackage

FILE: rtl/core/lbr_if.sv
// Handshake interfaces for the lattice reduction block: input and result words.
// Depends on lbr_pkg for field types.
interface lbr_in_if;
  logic          valid;
  logic          ready;
  lbr_pkg::comp_t a_x;
  lbr_pkg::comp_t a_y;
  lbr_pkg::comp_t b_x;
  lbr_pkg::comp_t b_y;

  modport source (output valid, a_x, a_y, b_x, b_y, input ready);
  modport sink   (input valid, a_x, a_y, b_x, b_y, output ready);
endinterface

interface lbr_out_if;
  logic          valid;
  logic          ready;
  lbr_pkg::vec_t red_a_x;
  lbr_pkg::vec_t red_a_y;
  lbr_pkg::vec_t red_b_x;
  lbr_pkg::vec_t red_b_y;

  modport source (output valid, red_a_x, red_a_y, red_b_x, red_b_y, input ready);
  modport sink   (input valid, red_a_x, red_a_y, red_b_x, red_b_y, output ready);
endinterface

FILE: rtl/core/lbr_dp.sv
// Datapath of the lattice reduction block: basis registers, candidate,
// squares, sums, compare and the result register. Depends on lbr_pkg.
module lbr_dp (
  input  logic              clk_i,
  input  lbr_pkg::comp_t    a_x_i,
  input  lbr_pkg::comp_t    a_y_i,
  input  lbr_pkg::comp_t    b_x_i,
  input  lbr_pkg::comp_t    b_y_i,
  input  lbr_pkg::lbr_cmd_t cmd_i,
  output lbr_pkg::lbr_sts_t sts_o,
  output lbr_pkg::vec_t     red_a_x_o,
  output lbr_pkg::vec_t     red_a_y_o,
  output lbr_pkg::vec_t     red_b_x_o,
  output lbr_pkg::vec_t     red_b_y_o
);
  import lbr_pkg::*;

  vec_t  ax_q, ay_q, bx_q, by_q;
  vec_t  tx, ty, ox, oy;
  cand_t cx_q, cy_q;
  sq_t   cx2_q, cy2_q, tx2_q, ty2_q;
  sum_t  csum_q, tsum_q;
  vec_t  ra_x_q, ra_y_q, rb_x_q, rb_y_q;
  logic  shorter;

  // target and other vector for this step
  always_comb begin
    tx = cmd_i.step[0] ? bx_q : ax_q;
    ty = cmd_i.step[0] ? by_q : ay_q;
    ox = cmd_i.step[0] ? ax_q : bx_q;
    oy = cmd_i.step[0] ? ay_q : by_q;
  end

  assign shorter       = csum_q < tsum_q;
  assign sts_o.shorter = shorter;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q <= vec_t'(a_x_i);
      ay_q <= vec_t'(a_y_i);
      bx_q <= vec_t'(b_x_i);
      by_q <= vec_t'(b_y_i);
    end else if (cmd_i.cmp && shorter) begin
      // a shorter vector always fits the output width
      if (cmd_i.step[0]) begin
        bx_q <= vec_t'(cx_q);
        by_q <= vec_t'(cy_q);
      end else begin
        ax_q <= vec_t'(cx_q);
        ay_q <= vec_t'(cy_q);
      end
    end

    if (cmd_i.cand) begin
      if (cmd_i.step[1]) begin
        cx_q <= cand_t'(tx) + cand_t'(ox);
        cy_q <= cand_t'(ty) + cand_t'(oy);
      end else begin
        cx_q <= cand_t'(tx) - cand_t'(ox);
        cy_q <= cand_t'(ty) - cand_t'(oy);
      end
    end

    if (cmd_i.sq) begin
      cx2_q <= sq_t'(cx_q * cx_q);
      cy2_q <= sq_t'(cy_q * cy_q);
      tx2_q <= sq_t'(cand_t'(tx) * cand_t'(tx));
      ty2_q <= sq_t'(cand_t'(ty) * cand_t'(ty));
    end

    if (cmd_i.sum) begin
      csum_q <= sum_t'(cx2_q) + sum_t'(cy2_q);
      tsum_q <= sum_t'(tx2_q) + sum_t'(ty2_q);
    end

    if (cmd_i.store_out) begin
      ra_x_q <= ax_q;
      ra_y_q <= ay_q;
      rb_x_q <= bx_q;
      rb_y_q <= by_q;
    end
  end

  assign red_a_x_o = ra_x_q;
  assign red_a_y_o = ra_y_q;
  assign red_b_x_o = rb_x_q;
  assign red_b_y_o = rb_y_q;

endmodule

FILE: rtl/core/lbr_ctrl.sv
// Controller of the lattice reduction block: step sequencing, pass
// termination and the input/result handshakes. Depends on lbr_pkg.
module lbr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lbr_pkg::lbr_cmd_t cmd_o,
  input  lbr_pkg::lbr_sts_t sts_i
);
  import lbr_pkg::*;

  lbr_state_e state_q, state_d;
  step_t      step_q, step_d;
  logic       moved_q, moved_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      moved_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      moved_q     <= moved_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    moved_d    = moved_q;
    cmd_o      = '0;
    cmd_o.step = step_q;
    in_ready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          moved_d    = 1'b0;
          state_d    = ST_CAND;
        end
      end
      ST_CAND: begin
        cmd_o.cand = 1'b1;
        state_d    = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        step_d    = step_q + step_t'(1);
        state_d   = ST_CAND;
        if (step_q == StepLast) begin
          // pass over: stop once a full pass left the basis alone
          moved_d = 1'b0;
          if (!(moved_q || sts_i.shorter)) begin
            state_d = ST_OUT;
          end
        end else if (sts_i.shorter) begin
          moved_d = 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.store_out = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.store_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/lattice_base_reduce_2d_top.sv
// Top level of the 2D lattice basis reduction block.
// Depends on lbr_pkg, lbr_if, lbr_ctrl and lbr_dp.

// Reduces a pair of signed 2D basis vectors (a, b) by unit steps: each pass
// tries a-b, b-a', a+b, b+a' in that order (a' being the a just updated) and
// keeps a candidate only when its squared length is strictly smaller; passes
// repeat until one changes nothing. One input word gives one result word.
// Each of the four candidate updates in a pass runs through the datapath
// steps in order: candidate add, squaring, sum, and compare with write back.
// The pass count depends on the data: one for an already reduced basis, up
// to about 32k (one unit step per pass) for the most skewed ones at the
// field extremes. One item is in work at a time; the input is ready only
// when the sequencer is idle. Results sit in an output register, so a new
// word can be accepted while the previous result still waits to be taken.
module lattice_base_reduce_2d_top (
  input  logic clk_i,
  input  logic rst_ni,
  lbr_in_if.sink    in_i,
  lbr_out_if.source out_o
);
  import lbr_pkg::*;

  lbr_cmd_t cmd;
  lbr_sts_t sts;

  // sequencer: owns the handshakes, step index and pass-changed flag
  lbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // basis registers, candidate arithmetic and result register
  lbr_dp u_dp (
    .clk_i     (clk_i),
    .a_x_i     (in_i.a_x),
    .a_y_i     (in_i.a_y),
    .b_x_i     (in_i.b_x),
    .b_y_i     (in_i.b_y),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .red_a_x_o (out_o.red_a_x),
    .red_a_y_o (out_o.red_a_y),
    .red_b_x_o (out_o.red_b_x),
    .red_b_y_o (out_o.red_b_y)
  );

endmodule

FILE: verif/lbr_reduce_checker.sv
`timescale 1ns / 100ps
// Checker for the 2D lattice basis reduction block: watches both channels,
// predicts each reduced pair and compares it with the result word.
// Depends on lbr_pkg and lbr_if.
module lbr_reduce_checker (
  input  logic clk_i,
  input  logic rst_ni,
  lbr_in_if    in_mon_i,
  lbr_out_if   out_mon_i,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   checked_o
);
  import lbr_pkg::*;

  typedef struct packed {
    vec_t ax;
    vec_t ay;
    vec_t bx;
    vec_t by;
  } red_pair_t;

  red_pair_t reduced_q[$];
  int        mismatches;
  int        results_seen;

  // Unit-step reduction; a candidate wins only when strictly shorter.
  function automatic red_pair_t reduce_basis(input comp_t ax_i, ay_i, bx_i, by_i);
    longint    ax, ay, bx, by, cx, cy;
    bit        moved;
    red_pair_t r;
    ax = ax_i;
    ay = ay_i;
    bx = bx_i;
    by = by_i;
    moved = 1'b1;
    while (moved) begin
      moved = 1'b0;
      for (int s = -1; s <= 1; s += 2) begin
        cx = ax + s * bx;
        cy = ay + s * by;
        if (cx * cx + cy * cy < ax * ax + ay * ay) begin
          ax = cx;
          ay = cy;
          moved = 1'b1;
        end
        cx = bx + s * ax;
        cy = by + s * ay;
        if (cx * cx + cy * cy < bx * bx + by * by) begin
          bx = cx;
          by = cy;
          moved = 1'b1;
        end
      end
    end
    r.ax = vec_t'(ax);
    r.ay = vec_t'(ay);
    r.bx = vec_t'(bx);
    r.by = vec_t'(by);
    return r;
  endfunction

  function automatic void match_field(input string name, input vec_t want, input vec_t got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    red_pair_t want;
    if (!rst_ni) begin
      reduced_q.delete();
      mismatches   = 0;
      results_seen = 0;
      fail_cnt_o  <= 0;
      pending_o   <= 0;
      checked_o   <= 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        reduced_q.push_back(reduce_basis(in_mon_i.a_x, in_mon_i.a_y,
                                         in_mon_i.b_x, in_mon_i.b_y));
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        results_seen++;
        if (reduced_q.size() == 0) begin
          $error("unexpected result word: (%0d,%0d) (%0d,%0d)",
                 out_mon_i.red_a_x, out_mon_i.red_a_y,
                 out_mon_i.red_b_x, out_mon_i.red_b_y);
          mismatches++;
        end else begin
          want = reduced_q.pop_front();
          match_field("red_a_x", want.ax, out_mon_i.red_a_x);
          match_field("red_a_y", want.ay, out_mon_i.red_a_y);
          match_field("red_b_x", want.bx, out_mon_i.red_b_x);
          match_field("red_b_y", want.by, out_mon_i.red_b_y);
        end
      end
      fail_cnt_o <= mismatches;
      pending_o  <= reduced_q.size();
      checked_o  <= results_seen;
    end
  end

endmodule

FILE: verif/lattice_base_reduce_2d_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for lattice_base_reduce_2d_top: drives basis words, toggles
// the result ready, and gives the verdict from the checker's failure and pending counts.
// Depends on lbr_pkg, lbr_if, lbr_reduce_checker and the block itself.
module lattice_base_reduce_2d_top_tb;
  import lbr_pkg::*;

  // One pathological item (collinear, max skew) takes ~32k passes; the watchdog
  // allows several times that long with no word moving.
  localparam int WatchdogLimit = 2_200_000;
  // Items per random phase; four phases plus the directed words give ~1050.
  localparam int PhaseItems    = 260;
  // Cycles to let pass once nothing is pending, before a phase switch or the end.
  localparam int SettleCycles  = 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  lbr_in_if  in_if ();
  lbr_out_if out_if ();

  int fail_cnt;
  int pending;
  int checked;
  int words_sent;
  int quiet_cycles;
  int src_idle_pct;
  int snk_stall_pct;

  always #5 clk_i = ~clk_i;

  lattice_base_reduce_2d_top dut (
    .clk_i,
    .rst_ni,
    .in_i  (in_if),
    .out_o (out_if)
  );

  lbr_reduce_checker chk (
    .clk_i,
    .rst_ni,
    .in_mon_i   (in_if),
    .out_mon_i  (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  // Result side: ready drops at random per the current stall percentage.
  always @(posedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(99) >= snk_stall_pct);
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("lattice_base_reduce_2d_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one basis word, after a random number of idle cycles, and holds it
  // until the block takes it. Valid stays high when no idle cycle is drawn.
  task automatic send_basis(input comp_t ax, ay, bx, by);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.a_x   <= ax;
    in_if.a_y   <= ay;
    in_if.b_x   <= bx;
    in_if.b_y   <= by;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
  endtask

  // Sender pauses until every predicted result has been checked.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int   kind;
    int   k, bx, by, ax, ay;
    comp_t rax, ray, rbx, rby;

    words_sent    = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    rst_ni        = 1'b0;
    in_if.valid  <= 1'b0;
    in_if.a_x    <= '0;
    in_if.a_y    <= '0;
    in_if.b_x    <= '0;
    in_if.b_y    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: zero vectors, field extremes, equal, opposite and
    // collinear pairs, ties on length, and one maximally skewed basis.
    send_basis(0, 0, 0, 0);
    send_basis(0, 0, 3, 4);
    send_basis(5, 7, 0, 0);
    send_basis(0, 0, -32768, 32767);
    send_basis(32767, 32767, -32768, -32768);
    send_basis(-32768, -32768, -32768, -32768);
    send_basis(32767, -32768, -32768, 32767);
    send_basis(-32768, 0, 0, -32768);
    send_basis(32767, 0, -32768, 0);
    send_basis(1, 0, 0, 1);
    send_basis(1, 0, -1, 1);        // a+b ties a on length: no move
    send_basis(1, 0, -1, 0);        // opposite unit vectors
    send_basis(-1, -1, -1, -1);
    send_basis(300, -200, 3, -2);   // collinear, a is a multiple of b
    send_basis(1000, 1, 999, 1);
    send_basis(12345, -6789, -4321, 9876);
    send_basis(-32767, 32766, 32766, -32767);
    send_basis(32767, -32768, 1, -1); // long run of unit steps
    drain();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct <= 0;  snk_stall_pct <= 0;  end
        1: begin src_idle_pct <= 80; snk_stall_pct <= 0;  end
        2: begin src_idle_pct <= 0;  snk_stall_pct <= 80; end
        default: begin src_idle_pct <= 36; snk_stall_pct <= 36; end
      endcase
      @(posedge clk_i);
      repeat (PhaseItems) begin
        kind = $urandom_range(99);
        if (kind < 40) begin
          // full range: every bit of every field toggles
          rax = comp_t'($urandom);
          ray = comp_t'($urandom);
          rbx = comp_t'($urandom);
          rby = comp_t'($urandom);
        end else if (kind < 65) begin
          rax = comp_t'(int'($urandom_range(63)) - 32);
          ray = comp_t'(int'($urandom_range(63)) - 32);
          rbx = comp_t'(int'($urandom_range(63)) - 32);
          rby = comp_t'(int'($urandom_range(63)) - 32);
        end else begin
          // skewed basis: one vector is about k times the other, so reduction needs ~k passes
          k  = int'($urandom_range(24, 1)) * ($urandom_range(1) ? 1 : -1);
          bx = int'($urandom_range(1000)) - 500;
          by = int'($urandom_range(1000)) - 500;
          ax = k * bx + int'($urandom_range(6)) - 3;
          ay = k * by + int'($urandom_range(6)) - 3;
          if ($urandom_range(1)) begin
            rax = comp_t'(ax); ray = comp_t'(ay); rbx = comp_t'(bx); rby = comp_t'(by);
          end else begin
            rax = comp_t'(bx); ray = comp_t'(by); rbx = comp_t'(ax); rby = comp_t'(ay);
          end
        end
        send_basis(rax, ray, rbx, rby);
      end
      drain();
    end

    $display("run covered %0d basis words, %0d reduced pairs checked", words_sent, checked);
    $display("directed extremes, zero/collinear/skewed bases, four idle/stall phases");
    if (fail_cnt == 0 && pending == 0) begin
      $display("lattice_base_reduce_2d_top verification clean");
    end else begin
      $display("lattice_base_reduce_2d_top verification failed");
    end
    $finish;
  end

endmodule
